// ===== hw/rtl/fpe_pkg.sv =====
package fpe_pkg;

  localparam int IN_W = 32;
  localparam int COMP_W = 34;
  localparam int ROW_COUNT = 3;
  localparam int COL_COUNT = 4;
  localparam int LEN_W = 35;
  localparam int ROOT_STEPS = 32;
  localparam int SQ_STEPS = 3;
  localparam int DEF_WORD_WIDTH = 32;
  localparam int DEF_FRAC_BITS = 16;
  localparam int PADDR_W = 3;
  localparam logic [1:0] TRIGGER_ROW = 2'd3;
  localparam logic ADDR_MIN_LENGTH = 1'b0;

  localparam logic [2:0] PLANE_LEFT = 3'd0;
  localparam logic [2:0] PLANE_RIGHT = 3'd1;
  localparam logic [2:0] PLANE_BOTTOM = 3'd2;
  localparam logic [2:0] PLANE_TOP = 3'd3;
  localparam logic [2:0] PLANE_NEAR = 3'd4;
  localparam logic [2:0] PLANE_FAR = 3'd5;

  typedef struct packed {
    logic [1:0] row_index;
    logic signed [IN_W-1:0] first_col;
    logic signed [IN_W-1:0] second_col;
    logic signed [IN_W-1:0] third_col;
    logic signed [IN_W-1:0] fourth_col;
  } in_item_t;

  typedef struct packed {
    logic [2:0] plane_index;
    logic signed [IN_W-1:0] normal_x;
    logic signed [IN_W-1:0] normal_y;
    logic signed [IN_W-1:0] normal_z;
    logic signed [IN_W-1:0] plane_offset;
    logic unnormalized;
    logic last_plane;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FORM,
    ST_SQUARE,
    ST_ROOT,
    ST_SETUP,
    ST_DIVIDE,
    ST_EMIT
  } fpe_state_t;

  typedef struct packed {
    logic store;
    logic capture;
    logic form;
    logic square;
    logic [1:0] sq_idx;
    logic root;
    logic setup;
    logic divide;
    logic emit;
    logic [2:0] plane;
  } fpe_cmd_t;

  function automatic logic signed [COMP_W-1:0] plane_comp(
    input logic [2:0] plane,
    input logic signed [IN_W-1:0] a,
    input logic signed [IN_W-1:0] b,
    input logic signed [IN_W-1:0] c,
    input logic signed [IN_W-1:0] d
  );
    logic signed [COMP_W-1:0] ea;
    logic signed [COMP_W-1:0] eb;
    logic signed [COMP_W-1:0] ec;
    logic signed [COMP_W-1:0] ed;
    logic signed [COMP_W-1:0] res;
    ea = COMP_W'(a);
    eb = COMP_W'(b);
    ec = COMP_W'(c);
    ed = COMP_W'(d);
    case (plane)
      PLANE_LEFT: res = -(ed + ea);
      PLANE_RIGHT: res = ea - ed;
      PLANE_BOTTOM: res = -(ed + eb);
      PLANE_TOP: res = eb - ed;
      PLANE_NEAR: res = -ec;
      default: res = ec - ed;
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/fpe_ctrl.sv =====
module fpe_ctrl
  import fpe_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [1:0] row_index,
  output logic busy,
  output fpe_cmd_t cmd
);

  localparam int DIV_STEPS = LEN_W + FRAC_BITS;
  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  fpe_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0] plane_r, plane_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      plane_r <= PLANE_LEFT;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      plane_r <= plane_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r + 1'b1;
    plane_nxt = plane_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (start && row_index == TRIGGER_ROW) begin
          state_nxt = ST_FORM;
          plane_nxt = PLANE_LEFT;
        end
      end
      ST_FORM: begin
        cnt_nxt = '0;
        state_nxt = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (cnt_r == CNT_W'(SQ_STEPS - 1)) begin
          cnt_nxt = '0;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (cnt_r == CNT_W'(ROOT_STEPS - 1)) begin
          cnt_nxt = '0;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cnt_nxt = '0;
        state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cnt_nxt = '0;
        if (plane_r == PLANE_FAR) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_FORM;
          plane_nxt = plane_r + 3'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt = '0;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.plane = plane_r;
    cmd.sq_idx = cnt_r[1:0];
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.store = start && row_index != TRIGGER_ROW;
        cmd.capture = start && row_index == TRIGGER_ROW;
      end
      ST_FORM: cmd.form = 1'b1;
      ST_SQUARE: cmd.square = 1'b1;
      ST_ROOT: cmd.root = 1'b1;
      ST_SETUP: cmd.setup = 1'b1;
      ST_DIVIDE: cmd.divide = 1'b1;
      ST_EMIT: cmd.emit = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

// ===== hw/rtl/fpe_datapath.sv =====
module fpe_datapath
  import fpe_pkg::*;
#(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  fpe_cmd_t cmd,
  input  in_item_t in_data,
  input  logic [15:0] min_length,
  output logic out_strobe,
  output out_item_t out_data
);

  localparam int DIV_W = LEN_W + FRAC_BITS;
  localparam int WIDE = 64;
  localparam logic signed [WIDE-1:0] SAT_HI = (64'sd1 <<< (WORD_WIDTH - 1)) - 64'sd1;
  localparam logic signed [WIDE-1:0] SAT_LO = -SAT_HI - 64'sd1;

  logic signed [IN_W-1:0] rows_r [ROW_COUNT+1][COL_COUNT];
  logic signed [COMP_W-1:0] v_r [COL_COUNT];
  logic [1:0] shift_r;
  logic [63:0] sum_r;
  logic [LEN_W-1:0] rem_r;
  logic [ROOT_STEPS-1:0] root_r;
  logic [LEN_W-1:0] len_r;
  logic norm_r;
  logic [LEN_W:0] drem_r [COL_COUNT];
  logic [DIV_W-1:0] dq_r [COL_COUNT];
  logic out_strobe_r;
  out_item_t out_data_r;

  logic [COMP_W-1:0] mag [COL_COUNT];
  logic [COMP_W-1:0] max_xy;
  logic [COMP_W-1:0] max_xyz;
  logic [1:0] shift_sel;
  logic [COMP_W:0] sq_round;
  logic [31:0] sq_a;
  logic [LEN_W-1:0] r2;
  logic [LEN_W-1:0] trial;
  logic [LEN_W-1:0] len_val;
  logic [LEN_W:0] dshift [COL_COUNT];
  logic signed [WIDE-1:0] res_val [COL_COUNT];
  logic [IN_W-1:0] res_field [COL_COUNT];

  always_comb begin
    for (int k = 0; k < COL_COUNT; k++) begin
      mag[k] = v_r[k][COMP_W-1] ? COMP_W'(-v_r[k]) : COMP_W'(v_r[k]);
    end
  end

  always_comb begin
    logic signed [COMP_W-1:0] fx;
    logic signed [COMP_W-1:0] fy;
    logic signed [COMP_W-1:0] fz;
    logic [COMP_W-1:0] ax;
    logic [COMP_W-1:0] ay;
    logic [COMP_W-1:0] az;
    fx = plane_comp(cmd.plane, rows_r[0][0], rows_r[0][1], rows_r[0][2], rows_r[0][3]);
    fy = plane_comp(cmd.plane, rows_r[1][0], rows_r[1][1], rows_r[1][2], rows_r[1][3]);
    fz = plane_comp(cmd.plane, rows_r[2][0], rows_r[2][1], rows_r[2][2], rows_r[2][3]);
    ax = fx[COMP_W-1] ? COMP_W'(-fx) : COMP_W'(fx);
    ay = fy[COMP_W-1] ? COMP_W'(-fy) : COMP_W'(fy);
    az = fz[COMP_W-1] ? COMP_W'(-fz) : COMP_W'(fz);
    max_xy = (ax > ay) ? ax : ay;
    max_xyz = (max_xy > az) ? max_xy : az;
    if (max_xyz[33]) begin
      shift_sel = 2'd3;
    end else if (max_xyz[32]) begin
      shift_sel = 2'd2;
    end else if (max_xyz[31]) begin
      shift_sel = 2'd1;
    end else begin
      shift_sel = 2'd0;
    end
  end

  assign sq_round = ({1'b0, mag[cmd.sq_idx]} +
                     (v_r[cmd.sq_idx][COMP_W-1] ?
                      ((COMP_W+1)'(1) << shift_r) - (COMP_W+1)'(1) : (COMP_W+1)'(0)))
                    >> shift_r;
  assign sq_a = sq_round[31:0];

  assign r2 = {rem_r[LEN_W-3:0], sum_r[63:62]};
  assign trial = {1'b0, root_r, 2'b01};
  assign len_val = LEN_W'(root_r) << shift_r;

  always_comb begin
    for (int k = 0; k < COL_COUNT; k++) begin
      dshift[k] = {drem_r[k][LEN_W-1:0], dq_r[k][DIV_W-1]};
    end
  end

  always_comb begin
    logic signed [WIDE-1:0] raw;
    for (int k = 0; k < COL_COUNT; k++) begin
      if (norm_r) begin
        raw = v_r[k][COMP_W-1] ? -$signed(WIDE'(dq_r[k])) : $signed(WIDE'(dq_r[k]));
      end else begin
        raw = WIDE'(v_r[k]);
      end
      if (raw > SAT_HI) begin
        res_val[k] = SAT_HI;
      end else if (raw < SAT_LO) begin
        res_val[k] = SAT_LO;
      end else begin
        res_val[k] = raw;
      end
      res_field[k] = res_val[k][IN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      rows_r[in_data.row_index][0] <= in_data.first_col;
      rows_r[in_data.row_index][1] <= in_data.second_col;
      rows_r[in_data.row_index][2] <= in_data.third_col;
      rows_r[in_data.row_index][3] <= in_data.fourth_col;
    end
    if (cmd.capture) begin
      rows_r[ROW_COUNT][0] <= in_data.first_col;
      rows_r[ROW_COUNT][1] <= in_data.second_col;
      rows_r[ROW_COUNT][2] <= in_data.third_col;
      rows_r[ROW_COUNT][3] <= in_data.fourth_col;
    end
    if (cmd.form) begin
      for (int k = 0; k < COL_COUNT; k++) begin
        v_r[k] <= plane_comp(cmd.plane, rows_r[k][0], rows_r[k][1], rows_r[k][2],
                             rows_r[k][3]);
      end
      shift_r <= shift_sel;
      sum_r <= '0;
      rem_r <= '0;
      root_r <= '0;
    end
    if (cmd.square) begin
      sum_r <= sum_r + 64'(sq_a) * 64'(sq_a);
    end
    if (cmd.root) begin
      sum_r <= {sum_r[61:0], 2'b00};
      if (r2 >= trial) begin
        rem_r <= r2 - trial;
        root_r <= {root_r[ROOT_STEPS-2:0], 1'b1};
      end else begin
        rem_r <= r2;
        root_r <= {root_r[ROOT_STEPS-2:0], 1'b0};
      end
    end
    if (cmd.setup) begin
      len_r <= len_val;
      norm_r <= len_val > LEN_W'(min_length);
      for (int k = 0; k < COL_COUNT; k++) begin
        drem_r[k] <= '0;
        dq_r[k] <= (DIV_W'(mag[k]) << FRAC_BITS) + DIV_W'(len_val >> 1);
      end
    end
    if (cmd.divide) begin
      for (int k = 0; k < COL_COUNT; k++) begin
        if (dshift[k] >= {1'b0, len_r}) begin
          drem_r[k] <= dshift[k] - {1'b0, len_r};
          dq_r[k] <= {dq_r[k][DIV_W-2:0], 1'b1};
        end else begin
          drem_r[k] <= dshift[k];
          dq_r[k] <= {dq_r[k][DIV_W-2:0], 1'b0};
        end
      end
    end
    if (cmd.emit) begin
      out_data_r.plane_index <= cmd.plane;
      out_data_r.normal_x <= res_field[0];
      out_data_r.normal_y <= res_field[1];
      out_data_r.normal_z <= res_field[2];
      out_data_r.plane_offset <= res_field[3];
      out_data_r.unnormalized <= !norm_r;
      out_data_r.last_plane <= cmd.plane == PLANE_FAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data = out_data_r;

endmodule

// ===== hw/rtl/frustum_plane_extract.sv =====
// Frustum plane extraction. Rows 0 to 2 of the matrix are each only stored. Row 3 starts
// the six planes, left, right, bottom, top, near and far, one result per plane on out_strobe
// for a single cycle; the receiver cannot stall, so results must be taken as they appear.
// Each plane passes through the one-bit-per-cycle square root and the one-bit-per-cycle
// dividers, and row 3 keeps busy high until the far plane has been emitted. The min_length
// register is selected when paddr bit 2 is 0, so it sits at addresses 0 to 3.
module frustum_plane_extract
  import fpe_pkg::*;
#(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_item_t in_data,
  output logic out_strobe,
  output out_item_t out_data,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  fpe_cmd_t cmd;
  logic [15:0] min_length_r;
  logic reg_sel;

  assign reg_sel = paddr[PADDR_W-1] == ADDR_MIN_LENGTH;
  assign pready = 1'b1;
  assign prdata = reg_sel ? {16'd0, min_length_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      min_length_r <= pwdata[15:0];
    end
  end

  fpe_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .row_index(in_data.row_index),
    .busy(busy),
    .cmd(cmd)
  );

  fpe_datapath #(
    .WORD_WIDTH(WORD_WIDTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_datapath (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .in_data(in_data),
    .min_length(min_length_r),
    .out_strobe(out_strobe),
    .out_data(out_data)
  );

endmodule
